>>> sv/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> sv/ddo_pkg.sv
package ddo_pkg;

  localparam int MUL_W        = 40;
  localparam int DIV_NW       = 64;
  localparam int DIV_DW       = 35;
  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_W     = 34;
  localparam int CORDIC_CW    = $clog2(CORDIC_STEPS);

  localparam logic [19:0] RADIUS_RST = 20'd100000;
  localparam logic [23:0] SEP_RST    = 24'd400000;

  localparam logic [MUL_W-1:0]  TWO_PI_Q24       = MUL_W'(105414357);
  localparam logic [MUL_W-1:0]  TURN_PER_RAD_Q16 = MUL_W'(683565276);
  localparam logic [MUL_W-1:0]  MICRO_MUL        = MUL_W'(1000000);
  localparam logic [DIV_DW-1:0] MICRO_DIV        = DIV_DW'(1000000);
  localparam logic [DIV_DW-1:0] SPEED_DIV        = DIV_DW'(64'd15360000000);
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = CORDIC_W'(652032874);

  // configuration register indexes
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_SEP    = 2'd1;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic [MUL_W-1:0] mag40(input logic signed [63:0] v);
    logic [63:0] t;
    t = v[63] ? 64'(-v) : 64'(v);
    return t[MUL_W-1:0];
  endfunction

  // arctangent of 2^-i in binary angle units (2^32 per turn)
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

>>> sv/ddo_in_if.sv
interface ddo_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] rpm_left;
  logic signed [15:0] rpm_right;
  logic        [23:0] dt_us;

  modport source (output valid, output rpm_left, output rpm_right, output dt_us,
                  input ready);
  modport sink (input valid, input rpm_left, input rpm_right, input dt_us,
                output ready);
endinterface

>>> sv/ddo_out_if.sv
interface ddo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] heading;
  logic signed [31:0] lin_vel;
  logic signed [31:0] ang_vel;

  modport source (output valid, output pos_x, output pos_y, output heading,
                  output lin_vel, output ang_vel, input ready);
  modport sink (input valid, input pos_x, input pos_y, input heading,
                input lin_vel, input ang_vel, output ready);
endinterface

>>> sv/ddo_cfg_if.sv
interface ddo_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  idx;
  logic [23:0] data;

  modport source (output valid, output idx, output data, input ready);
  modport sink (input valid, input idx, input data, output ready);
endinterface

>>> sv/ddo_ser_mul.sv
module ddo_ser_mul import ddo_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [MUL_W-1:0]     a_mag,
  input  logic [MUL_W-1:0]     b_mag,
  output logic [2*MUL_W-1:0]   p_mag,
  output unit_stat_t           stat
);

  localparam int CW = $clog2(MUL_W);

  logic [MUL_W-1:0] a_r, hi_r, lo_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r;
  logic [MUL_W:0]   sum;

  // one multiplier bit per cycle, lsb first
  assign sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(MUL_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      a_r  <= a_mag;
      hi_r <= '0;
      lo_r <= b_mag;
    end else if (busy_r) begin
      hi_r <= sum[MUL_W:1];
      lo_r <= {sum[0], lo_r[MUL_W-1:1]};
    end
  end

  assign p_mag     = {hi_r, lo_r};
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

>>> sv/ddo_ser_div.sv
module ddo_ser_div import ddo_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_NW-1:0]  n_mag,
  input  logic [DIV_DW-1:0]  d,
  output logic [DIV_NW-1:0]  q_mag,
  output unit_stat_t         stat
);

  localparam int CW = $clog2(DIV_NW);

  logic [DIV_NW-1:0] m_r;
  logic [DIV_DW-1:0] d_r, rem_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r, done_r;
  logic [DIV_DW:0]   trial, diff;
  logic              ge;

  // restoring division, one quotient bit per cycle, msb first
  assign trial = {rem_r, m_r[DIV_NW-1]};
  assign ge    = trial >= {1'b0, d_r};
  assign diff  = trial - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DIV_NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      // half the divisor added first: round to nearest, ties away from zero
      m_r   <= n_mag + DIV_NW'(d >> 1);
      d_r   <= d;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
      m_r   <= {m_r[DIV_NW-2:0], ge};
    end
  end

  assign q_mag     = m_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

>>> sv/ddo_cordic.sv
module ddo_cordic import ddo_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [31:0]                phase,
  output logic signed [CORDIC_W-1:0] cos_o,
  output logic signed [CORDIC_W-1:0] sin_o,
  output unit_stat_t                 stat
);

  localparam logic signed [CORDIC_W-1:0] QUARTER = CORDIC_W'(64'sd1073741824);
  localparam logic signed [CORDIC_W-1:0] HALF    = CORDIC_W'(64'sd2147483648);

  logic signed [CORDIC_W-1:0] x_r, y_r, z_r, xs, ys, at, z0, xn, yn;
  logic                       flip_r, busy_r, done_r;
  logic [CORDIC_CW-1:0]       cnt_r;
  logic [4:0]                 idx;

  assign idx = 5'(cnt_r);
  assign xs  = x_r >>> idx;
  assign ys  = y_r >>> idx;
  assign at  = CORDIC_W'(atan_turn(idx));
  assign z0  = CORDIC_W'($signed(phase));
  assign xn  = (z_r >= 0) ? x_r - ys : x_r + ys;
  assign yn  = (z_r >= 0) ? y_r + xs : y_r - xs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CORDIC_CW'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      x_r <= CORDIC_GAIN;
      y_r <= '0;
      // fold the back half plane onto the front one
      if (z0 >= QUARTER) begin
        z_r    <= z0 - HALF;
        flip_r <= 1'b1;
      end else if (z0 < -QUARTER) begin
        z_r    <= z0 + HALF;
        flip_r <= 1'b1;
      end else begin
        z_r    <= z0;
        flip_r <= 1'b0;
      end
    end else if (busy_r) begin
      x_r <= xn;
      y_r <= yn;
      z_r <= (z_r >= 0) ? z_r - at : z_r + at;
      if (cnt_r == CORDIC_CW'(CORDIC_STEPS - 1)) begin
        cos_o <= flip_r ? -xn : xn;
        sin_o <= flip_r ? -yn : yn;
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

>>> sv/diff_drive_odometry_unit.sv
// differential-drive odometry, q16.16 outputs
// in_ch takes one sample (left/right rpm, interval in us); out_ch returns one
// result per sample: integrated x, y, heading and the linear and angular velocity.
// cfg_ch writes wheel radius (index 0) and wheel separation (index 1) in um;
// cfg_ch.ready is always high, writes belong in idle periods.
// one shared bit-serial multiplier, one restoring divider and an iterative cordic
// do all the math; a sequencer runs ten products, five quotients and one rotation
// per sample. out_ch.valid rises once the sequencer has run all of those steps;
// one sample is in flight at a time: a new sample is taken only in the idle state.
// the result sits in an output register: the next sample is accepted as soon as
// it is loaded, even while out_ch.ready is low; if the old result is still not
// taken when the next one is done, the sequencer waits in its last step.
// synchronous active-low reset clears position and heading to zero and restores
// radius 100000 um and separation 400000 um.
`include "assert_macros.svh"

module diff_drive_odometry_unit import ddo_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ddo_in_if.sink     in_ch,
  ddo_out_if.source  out_ch,
  ddo_cfg_if.sink    cfg_ch
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_ML1  = 5'd1;
  localparam logic [4:0] ST_ML2  = 5'd2;
  localparam logic [4:0] ST_DL   = 5'd3;
  localparam logic [4:0] ST_MR1  = 5'd4;
  localparam logic [4:0] ST_MR2  = 5'd5;
  localparam logic [4:0] ST_DR   = 5'd6;
  localparam logic [4:0] ST_MA   = 5'd7;
  localparam logic [4:0] ST_DA   = 5'd8;
  localparam logic [4:0] ST_MH   = 5'd9;
  localparam logic [4:0] ST_DH   = 5'd10;
  localparam logic [4:0] ST_MD   = 5'd11;
  localparam logic [4:0] ST_DD   = 5'd12;
  localparam logic [4:0] ST_MP   = 5'd13;
  localparam logic [4:0] ST_CO   = 5'd14;
  localparam logic [4:0] ST_MX   = 5'd15;
  localparam logic [4:0] ST_MY   = 5'd16;
  localparam logic [4:0] ST_OUT  = 5'd17;

  logic [4:0]         state_r;
  logic               go_r, neg_r;
  logic [19:0]        rad_r;
  logic [23:0]        sep_r;
  logic signed [15:0] rl_r, rr_r;
  logic [23:0]        dt_r;
  logic signed [31:0] vl_r, lin_r, ang_r;
  logic signed [32:0] diff_r;
  logic [31:0]        hd_r, ax_r, ay_r, phase_r;
  logic [DIV_DW-1:0]  dist_r;
  logic               dist_neg_r;
  logic               out_valid_r;
  logic [31:0]        ox_r, oy_r, oh_r, ol_r, oa_r;

  logic in_fire, cfg_fire, is_mul, is_div, unit_done;
  logic mul_start, div_start, cor_start, mul_neg;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_p;
  logic [DIV_DW-1:0]  div_d;
  logic [DIV_NW-1:0]  div_q;
  logic signed [CORDIC_W-1:0] cos_v, sin_v;
  unit_stat_t mul_st, div_st, cor_st;

  logic signed [31:0] q_s32;
  logic signed [32:0] vsum;
  logic [32:0]        vsum_mag, lin_mag;
  logic signed [31:0] lin_nxt, ang_nxt;
  logic [47:0]        ph_low, ph_rnd;
  logic [61:0]        d_rnd;
  logic [31:0]        d_s32;
  logic               out_load;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    is_mul = state_r inside {ST_ML1, ST_ML2, ST_MR1, ST_MR2, ST_MA, ST_MH, ST_MD,
                             ST_MP, ST_MX, ST_MY};
    is_div = state_r inside {ST_DL, ST_DR, ST_DA, ST_DH, ST_DD};
    mul_start = is_mul && !go_r;
    div_start = is_div && !go_r;
    cor_start = (state_r == ST_CO) && !go_r;
    if (is_mul)
      unit_done = mul_st.done;
    else if (is_div)
      unit_done = div_st.done;
    else
      unit_done = (state_r == ST_CO) && cor_st.done;
  end

  // operand selection for the shared multiplier
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = neg_r;
    case (state_r)
      ST_ML1: begin
        mul_a   = mag40(64'(rl_r));
        mul_b   = MUL_W'(rad_r);
        mul_neg = rl_r[15];
      end
      ST_MR1: begin
        mul_a   = mag40(64'(rr_r));
        mul_b   = MUL_W'(rad_r);
        mul_neg = rr_r[15];
      end
      ST_ML2, ST_MR2: begin
        mul_a = mul_p[MUL_W-1:0];
        mul_b = TWO_PI_Q24;
      end
      ST_MA: begin
        mul_a   = mag40(64'(diff_r));
        mul_b   = MICRO_MUL;
        mul_neg = diff_r[32];
      end
      ST_MH: begin
        mul_a   = mag40(64'(ang_r));
        mul_b   = MUL_W'(dt_r);
        mul_neg = ang_r[31];
      end
      ST_MD: begin
        mul_a   = mag40(64'(lin_r));
        mul_b   = MUL_W'(dt_r);
        mul_neg = lin_r[31];
      end
      ST_MP: begin
        mul_a   = mag40(64'($signed(hd_r)));
        mul_b   = TURN_PER_RAD_Q16;
        mul_neg = hd_r[31];
      end
      ST_MX: begin
        mul_a   = MUL_W'(dist_r);
        mul_b   = mag40(64'(cos_v));
        mul_neg = dist_neg_r ^ cos_v[CORDIC_W-1];
      end
      ST_MY: begin
        mul_a   = MUL_W'(dist_r);
        mul_b   = mag40(64'(sin_v));
        mul_neg = dist_neg_r ^ sin_v[CORDIC_W-1];
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_comb begin
    case (state_r)
      ST_DL, ST_DR: div_d = SPEED_DIV;
      ST_DA:        div_d = (sep_r == '0) ? DIV_DW'(1) : DIV_DW'(sep_r);
      default:      div_d = MICRO_DIV;
    endcase
  end

  // result shaping
  always_comb begin
    q_s32    = neg_r ? -$signed(div_q[31:0]) : $signed(div_q[31:0]);
    vsum     = 33'(vl_r) + 33'(q_s32);
    vsum_mag = vsum[32] ? 33'(-vsum) : 33'(vsum);
    lin_mag  = (vsum_mag + 33'd1) >> 1;
    lin_nxt  = vsum[32] ? -$signed(lin_mag[31:0]) : $signed(lin_mag[31:0]);
    if (!neg_r && div_q > DIV_NW'(32'h7FFFFFFF))
      ang_nxt = 32'sh7FFFFFFF;
    else if (neg_r && div_q > DIV_NW'(32'h80000000))
      ang_nxt = 32'sh80000000;
    else
      ang_nxt = q_s32;
    ph_low = neg_r ? -mul_p[47:0] : mul_p[47:0];
    ph_rnd = ph_low + 48'h8000;
    d_rnd  = mul_p[61:0] + 62'h2000_0000;
    d_s32  = neg_r ? -d_rnd[61:30] : d_rnd[61:30];
  end

  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      go_r        <= 1'b0;
      rad_r       <= RADIUS_RST;
      sep_r       <= SEP_RST;
      hd_r        <= '0;
      ax_r        <= '0;
      ay_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_fire) begin
        case (cfg_ch.idx)
          REG_RADIUS: rad_r <= cfg_ch.data[19:0];
          REG_SEP:    sep_r <= cfg_ch.data;
          default:    ;
        endcase
      end
      go_r <= (go_r || mul_start || div_start || cor_start) && !unit_done;
      if (out_load)
        out_valid_r <= 1'b1;
      else if (out_ch.ready)
        out_valid_r <= 1'b0;

      if (state_r == ST_IDLE) begin
        if (in_fire)
          state_r <= ST_ML1;
      end else if (state_r == ST_OUT) begin
        if (out_load)
          state_r <= ST_IDLE;
      end else if (unit_done) begin
        state_r <= state_r + 5'd1;
        case (state_r)
          ST_DH:   hd_r <= hd_r + 32'(q_s32);
          ST_MX:   ax_r <= ax_r + d_s32;
          ST_MY:   ay_r <= ay_r + d_s32;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rl_r <= in_ch.rpm_left;
      rr_r <= in_ch.rpm_right;
      dt_r <= in_ch.dt_us;
    end
    if (mul_start)
      neg_r <= mul_neg;
    if (unit_done) begin
      case (state_r)
        ST_DL: vl_r <= q_s32;
        ST_DR: begin
          lin_r  <= lin_nxt;
          diff_r <= 33'(q_s32) - 33'(vl_r);
        end
        ST_DA: ang_r <= ang_nxt;
        ST_DD: begin
          dist_r     <= div_q[DIV_DW-1:0];
          dist_neg_r <= neg_r;
        end
        ST_MP:   phase_r <= ph_rnd[47:16];
        default: ;
      endcase
    end
    if (out_load) begin
      ox_r <= ax_r;
      oy_r <= ay_r;
      oh_r <= hd_r;
      ol_r <= lin_r;
      oa_r <= ang_r;
    end
  end

  ddo_ser_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a_mag (mul_a),
    .b_mag (mul_b),
    .p_mag (mul_p),
    .stat  (mul_st)
  );

  ddo_ser_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .n_mag (mul_p[DIV_NW-1:0]),
    .d     (div_d),
    .q_mag (div_q),
    .stat  (div_st)
  );

  ddo_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .phase (phase_r),
    .cos_o (cos_v),
    .sin_o (sin_v),
    .stat  (cor_st)
  );

  assign out_ch.valid   = out_valid_r;
  assign out_ch.pos_x   = ox_r;
  assign out_ch.pos_y   = oy_r;
  assign out_ch.heading = oh_r;
  assign out_ch.lin_vel = ol_r;
  assign out_ch.ang_vel = oa_r;

  `ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_fire, state_r != ST_IDLE)
  `ASSERT_IMPL(a_one_unit, clk, rst_n, div_st.busy, !mul_st.busy && !cor_st.busy)
  `ASSERT_IMPL(a_idle_quiet, clk, rst_n, state_r == ST_IDLE, !mul_st.busy && !div_st.busy && !cor_st.busy)

endmodule

>>> tb/diff_drive_odometry_unit_tb.sv
module diff_drive_odometry_unit_tb;
  import ddo_pkg::*;

  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
    logic signed [31:0] lin_vel;
    logic signed [31:0] ang_vel;
  } pose_t;

  class odom_scoreboard;
    logic [19:0] radius_um;
    logic [23:0] sep_um;
    logic [31:0] x_acc, y_acc, hdg_acc;
    pose_t       pose_q[$];
    int          errors;
    longint      atan_q30[24] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
      64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
      64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

    function void clear();
      radius_um = RADIUS_RST;
      sep_um    = SEP_RST;
      x_acc = 0; y_acc = 0; hdg_acc = 0;
      pose_q.delete();
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [23:0] data);
      if (idx == REG_RADIUS) radius_um = data[19:0];
      else if (idx == REG_SEP) sep_um = data;
    endfunction

    // divide rounding to nearest, ties away from zero
    function longint round_div(longint n, longint unsigned d);
      bit neg;
      longint unsigned m, q;
      neg = n < 0;
      m = neg ? longint'(-n) : n;
      q = (m + d / 2) / d;
      return neg ? -longint'(q) : longint'(q);
    endfunction

    function longint ground_speed(logic signed [15:0] rpm);
      return round_div(longint'(rpm) * longint'(radius_um) * 105414357, 64'd15360000000);
    endfunction

    function void rotate(logic [31:0] hdg, output longint c, output longint s);
      longint p, z, x, y, xs, ys;
      logic [63:0] u;
      bit flip;
      p = longint'(signed'(hdg)) * 683565276;
      u = 64'(p) + 64'h8000;
      z = longint'(signed'(u[47:16]));
      flip = 0;
      if (z >= (64'sd1 << 30)) begin
        z -= (64'sd1 << 31); flip = 1;
      end else if (z < -(64'sd1 << 30)) begin
        z += (64'sd1 << 31); flip = 1;
      end
      x = 652032874; y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs = x >>> i; ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= atan_q30[i];
        end else begin
          x += ys; y -= xs; z += atan_q30[i];
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function void note_sample(logic signed [15:0] rl, logic signed [15:0] rr, logic [23:0] dt);
      longint vl, vr, lin, ang, dth, travel, c, s, dx, dy;
      longint unsigned sep;
      pose_t p;
      sep = (sep_um == 0) ? 1 : sep_um;
      vl = ground_speed(rl);
      vr = ground_speed(rr);
      lin = round_div(vl + vr, 2);
      ang = round_div((vr - vl) * 1000000, sep);
      if (ang > 64'sd2147483647) ang = 64'sd2147483647;
      if (ang < -64'sd2147483648) ang = -64'sd2147483648;
      dth = round_div(ang * longint'(dt), 1000000);
      hdg_acc += 32'(dth);
      travel = round_div(lin * longint'(dt), 1000000);
      rotate(hdg_acc, c, s);
      dx = round_div(travel * c, 64'd1 << 30);
      dy = round_div(travel * s, 64'd1 << 30);
      x_acc += 32'(dx);
      y_acc += 32'(dy);
      p.pos_x = x_acc; p.pos_y = y_acc; p.heading = hdg_acc;
      p.lin_vel = 32'(lin); p.ang_vel = 32'(ang);
      pose_q.push_back(p);
    endfunction

    function void check_pose(pose_t got);
      pose_t e;
      if (pose_q.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
        return;
      end
      e = pose_q.pop_front();
      if (got.pos_x !== e.pos_x) begin
        $error("pos_x exp %0d got %0d", e.pos_x, got.pos_x); errors++;
      end
      if (got.pos_y !== e.pos_y) begin
        $error("pos_y exp %0d got %0d", e.pos_y, got.pos_y); errors++;
      end
      if (got.heading !== e.heading) begin
        $error("heading exp %0d got %0d", e.heading, got.heading); errors++;
      end
      if (got.lin_vel !== e.lin_vel) begin
        $error("lin_vel exp %0d got %0d", e.lin_vel, got.lin_vel); errors++;
      end
      if (got.ang_vel !== e.ang_vel) begin
        $error("ang_vel exp %0d got %0d", e.ang_vel, got.ang_vel); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  ddo_in_if  in_ch();
  ddo_out_if out_ch();
  ddo_cfg_if cfg_ch();

  diff_drive_odometry_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  odom_scoreboard sb = new();
  longint cycles = 0;
  int     burst_left = 0;
  int     stall_mode = 0;
  int     stall_cnt = 0;

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  always @(posedge clk) begin
    pose_t got;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_sample(in_ch.rpm_left, in_ch.rpm_right, in_ch.dt_us);
      if (cfg_ch.valid && cfg_ch.ready)
        sb.write_reg(cfg_ch.idx, cfg_ch.data);
      if (out_ch.valid && out_ch.ready) begin
        got.pos_x = out_ch.pos_x; got.pos_y = out_ch.pos_y; got.heading = out_ch.heading;
        got.lin_vel = out_ch.lin_vel; got.ang_vel = out_ch.ang_vel;
        sb.check_pose(got);
      end
    end
  end

  // receiver back-pressure: always ready, coin flip, or mostly stalled
  always @(negedge clk) begin
    stall_cnt++;
    if (stall_cnt >= 300) begin
      stall_cnt = 0;
      stall_mode = $urandom_range(0, 2);
    end
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= $urandom_range(0, 1);
      default: out_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send_sample(logic signed [15:0] rl, logic signed [15:0] rr, logic [23:0] dt);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.rpm_left = rl;
    in_ch.rpm_right = rr;
    in_ch.dt_us = dt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    burst_left = 0;
    while (sb.pose_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] data);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.idx = idx;
    cfg_ch.data = data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic random_sample();
    logic signed [15:0] rl, rr;
    logic [23:0] dt;
    case ($urandom_range(0, 3))
      0: begin rl = $urandom; rr = $urandom; end
      1: begin rl = $urandom_range(0, 400) - 200; rr = $urandom_range(0, 400) - 200; end
      2: begin rl = $urandom_range(0, 6000) - 3000; rr = rl + $urandom_range(0, 200) - 100; end
      default: begin rl = $urandom; rr = -rl; end
    endcase
    case ($urandom_range(0, 4))
      0: dt = $urandom;
      1: dt = 0;
      default: dt = $urandom_range(1, 50000);
    endcase
    send_sample(rl, rr, dt);
  endtask

  initial begin
    logic [19:0] rad;
    logic [23:0] sep;
    rst_n = 1'b0;
    in_ch.valid = 1'b0; in_ch.rpm_left = 0; in_ch.rpm_right = 0; in_ch.dt_us = 0;
    cfg_ch.valid = 1'b0; cfg_ch.idx = REG_RADIUS; cfg_ch.data = 0;
    out_ch.ready = 1'b0;
    sb.clear();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // extremes and ordinary samples at reset settings
    send_sample(16'sh7FFF, 16'sh7FFF, 24'hFFFFFF);
    send_sample(-16'sh8000, -16'sh8000, 24'hFFFFFF);
    send_sample(-16'sh8000, 16'sh7FFF, 24'hFFFFFF);
    send_sample(16'sh7FFF, -16'sh8000, 24'd1);
    send_sample(16'sd100, 16'sd300, 24'd0);
    send_sample(16'sd0, 16'sd0, 24'd1000);
    send_sample(16'sd60, 16'sd60, 24'd250000);
    send_sample(-16'sd60, 16'sd60, 24'd500000);
    drain();

    // zero radius and zero separation, then full-scale radius and separation, with angular saturation
    write_reg(REG_RADIUS, 24'd0);
    write_reg(REG_SEP, 24'd0);
    send_sample(16'sh7FFF, -16'sh8000, 24'hFFFFFF);
    drain();
    write_reg(REG_RADIUS, 24'hFFFFF);
    send_sample(16'sh7FFF, -16'sh8000, 24'hFFFFFF);
    send_sample(-16'sh8000, 16'sh7FFF, 24'hFFFFFF);
    send_sample(16'sh7FFF, 16'sh7FFF, 24'hFFFFFF);
    drain();
    write_reg(REG_SEP, 24'hFFFFFF);
    send_sample(16'sh7FFF, -16'sh8000, 24'hFFFFFF);
    send_sample(-16'sh8000, -16'sh8000, 24'hFFFFFF);
    send_sample(16'sd1, -16'sd1, 24'd123456);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin rad = RADIUS_RST; sep = SEP_RST; end
        1: begin rad = 20'd1; sep = 24'd1; end
        2: begin rad = 20'hFFFFF; sep = 24'hFFFFFF; end
        3: begin rad = $urandom_range(1000, 300000); sep = $urandom_range(50000, 2000000); end
        4: begin rad = 0; sep = 0; end
        default: begin rad = $urandom; sep = $urandom; end
      endcase
      write_reg(REG_RADIUS, 24'(rad));
      write_reg(REG_SEP, sep);
      for (int n = 0; n < 120; n++) begin
        random_sample();
        if (ph == 3 && n == 60) drain();
      end
      drain();
    end

    drain();
    repeat (1000) @(negedge clk);
    if (sb.errors == 0 && sb.pose_q.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  always @(negedge clk)
    if (rst_n && sb.pose_q.size() > 1 && sb.errors == -1) $display("unreachable");

endmodule
